// File: rtl/mco_pkg.sv
`default_nettype none

package mco_pkg;

  // Input item function codes.
  localparam logic FUNC_START = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  // Default widths.
  localparam int COORD_WIDTH_DEF  = 16;
  localparam int RADIUS_WIDTH_DEF = 13;

  // Entries in the queue between the front and the back end.
  localparam int QUEUE_DEPTH = 2;

  // Symmetric points per octant set, and the index width that walks them.
  localparam int PTS    = 8;
  localparam int PTS_IW = $clog2(PTS);

  // Per point k, bit k of each mask: swap u and v, negate x, negate y.
  // Order: (u,v) (v,u) (v,-u) (u,-v) (-u,-v) (-v,-u) (-v,u) (-u,v).
  localparam logic [PTS-1:0] PT_SWAP = 8'b0110_0110;
  localparam logic [PTS-1:0] PT_NEGX = 8'b1111_0000;
  localparam logic [PTS-1:0] PT_NEGY = 8'b0011_1100;

  // Control part of one queued job.
  typedef struct packed {
    logic pts;   // 1: emit eight points, 0: emit one done marker
    logic done;  // outline complete after this job
  } mco_ctl_t;

endpackage

`default_nettype wire

// File: rtl/mco_queue.sv
`default_nettype none

module mco_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] din,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      dout,
  output logic              nempty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r,    cnt_nxt;

  assign full   = (cnt_r == CW'(DEPTH));
  assign nempty = (cnt_r != '0);
  assign dout   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= din;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mco_front.sv
`default_nettype none

module mco_front #(
  parameter int COORD_WIDTH  = mco_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mco_pkg::RADIUS_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic signed [COORD_WIDTH-2:0]  in_center_x,
  input  wire logic signed [COORD_WIDTH-2:0]  in_center_y,
  input  wire logic        [RADIUS_WIDTH-1:0] in_radius,
  input  wire logic                           q_full,
  output logic                                q_push,
  output mco_pkg::mco_ctl_t                   job_ctl,
  output logic signed [COORD_WIDTH-2:0]       job_cx,
  output logic signed [COORD_WIDTH-2:0]       job_cy,
  output logic        [RADIUS_WIDTH-1:0]      job_u,
  output logic        [RADIUS_WIDTH-1:0]      job_v
);

  import mco_pkg::*;

  // The decision variable stays within a few times the radius.
  localparam int DW = RADIUS_WIDTH + 3;

  logic signed [COORD_WIDTH-2:0]  cx_r,     cx_nxt;
  logic signed [COORD_WIDTH-2:0]  cy_r,     cy_nxt;
  logic        [RADIUS_WIDTH-1:0] u_r,      u_nxt;
  logic        [RADIUS_WIDTH-1:0] v_r,      v_nxt;
  logic signed [DW-1:0]           dec_r,    dec_nxt;
  logic                           active_r, active_nxt;
  logic                           accept;
  logic signed [DW-1:0]           two_u;
  logic signed [DW-1:0]           two_v;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  assign two_u = $signed({2'b00, u_r, 1'b0});
  assign two_v = $signed({2'b00, v_r, 1'b0});

  always_comb begin
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    u_nxt      = u_r;
    v_nxt      = v_r;
    dec_nxt    = dec_r;
    active_nxt = active_r;
    job_ctl.pts  = 1'b1;
    job_ctl.done = 1'b0;
    if (in_func == FUNC_START) begin
      cx_nxt     = in_center_x;
      cy_nxt     = in_center_y;
      u_nxt      = '0;
      v_nxt      = in_radius;
      dec_nxt    = DW'(1) - $signed({3'b000, in_radius});
      active_nxt = 1'b1;
      job_ctl.done = (in_radius == '0);
    end else if (!active_r || (u_r >= v_r)) begin
      // Nothing left to draw: a single done marker.
      job_ctl.pts  = 1'b0;
      job_ctl.done = 1'b1;
    end else begin
      u_nxt = u_r + 1'b1;
      if (dec_r[DW-1]) begin
        dec_nxt = dec_r + two_u + DW'(3);
      end else begin
        dec_nxt = dec_r + (two_u - two_v) + DW'(5);
        v_nxt   = v_r - 1'b1;
      end
      job_ctl.done = (u_nxt >= v_nxt);
    end
  end

  assign job_cx = cx_nxt;
  assign job_cy = cy_nxt;
  assign job_u  = u_nxt;
  assign job_v  = v_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r     <= '0;
      cy_r     <= '0;
      u_r      <= '0;
      v_r      <= '0;
      dec_r    <= '0;
      active_r <= 1'b0;
    end else if (accept) begin
      cx_r     <= cx_nxt;
      cy_r     <= cy_nxt;
      u_r      <= u_nxt;
      v_r      <= v_nxt;
      dec_r    <= dec_nxt;
      active_r <= active_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/mco_back.sv
`default_nettype none

module mco_back #(
  parameter int COORD_WIDTH  = mco_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mco_pkg::RADIUS_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_nempty,
  output logic                                q_pop,
  input  wire mco_pkg::mco_ctl_t              head_ctl,
  input  wire logic signed [COORD_WIDTH-2:0]  head_cx,
  input  wire logic signed [COORD_WIDTH-2:0]  head_cy,
  input  wire logic        [RADIUS_WIDTH-1:0] head_u,
  input  wire logic        [RADIUS_WIDTH-1:0] head_v,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_point_x,
  output logic signed [COORD_WIDTH-1:0]       out_point_y,
  output logic                                out_point_valid,
  output logic                                out_last_of_run,
  output logic                                out_done_res
);

  import mco_pkg::*;

  logic                           busy_r;
  logic [PTS_IW-1:0]              k_r;
  logic signed [COORD_WIDTH-2:0]  cx_r;
  logic signed [COORD_WIDTH-2:0]  cy_r;
  logic        [RADIUS_WIDTH-1:0] u_r;
  logic        [RADIUS_WIDTH-1:0] v_r;
  logic                           done_r;
  logic                           out_valid_r;
  logic signed [COORD_WIDTH-1:0]  px_r, py_r;
  logic                           pv_r, last_r, dres_r;

  logic                           adv;
  logic                           emit;
  logic [PTS_IW-1:0]              k_sel;
  logic signed [COORD_WIDTH-2:0]  cx_sel, cy_sel;
  logic        [RADIUS_WIDTH-1:0] u_sel, v_sel, a_sel, b_sel;
  logic signed [COORD_WIDTH-1:0]  cx_ext, cy_ext;
  logic signed [COORD_WIDTH-1:0]  a_ext, b_ext;
  logic signed [COORD_WIDTH-1:0]  px_calc, py_calc;
  logic                           pv_calc, last_calc, dres_calc;

  // The output register moves when it is empty or being taken.
  assign adv   = !out_valid_r || !out_stall;
  assign emit  = adv && (busy_r || q_nempty);
  assign q_pop = adv && !busy_r && q_nempty;

  // The first point of a job comes straight from the queue head.
  assign k_sel  = busy_r ? k_r  : '0;
  assign cx_sel = busy_r ? cx_r : head_cx;
  assign cy_sel = busy_r ? cy_r : head_cy;
  assign u_sel  = busy_r ? u_r  : head_u;
  assign v_sel  = busy_r ? v_r  : head_v;

  assign a_sel  = PT_SWAP[k_sel] ? v_sel : u_sel;
  assign b_sel  = PT_SWAP[k_sel] ? u_sel : v_sel;
  assign cx_ext = COORD_WIDTH'(cx_sel);
  assign cy_ext = COORD_WIDTH'(cy_sel);
  assign a_ext  = $signed(COORD_WIDTH'(a_sel));
  assign b_ext  = $signed(COORD_WIDTH'(b_sel));

  always_comb begin
    pv_calc   = busy_r || head_ctl.pts;
    last_calc = busy_r ? (k_r == PTS_IW'(PTS - 1)) : !head_ctl.pts;
    dres_calc = busy_r ? done_r : head_ctl.done;
    if (pv_calc) begin
      px_calc = PT_NEGX[k_sel] ? (cx_ext - a_ext) : (cx_ext + a_ext);
      py_calc = PT_NEGY[k_sel] ? (cy_ext - b_ext) : (cy_ext + b_ext);
    end else begin
      px_calc = '0;
      py_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
      if (busy_r) begin
        k_r <= k_r + 1'b1;
        if (k_r == PTS_IW'(PTS - 1)) begin
          busy_r <= 1'b0;
        end
      end else if (q_nempty) begin
        busy_r <= head_ctl.pts;
        k_r    <= PTS_IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cx_r   <= head_cx;
      cy_r   <= head_cy;
      u_r    <= head_u;
      v_r    <= head_v;
      done_r <= head_ctl.done;
    end
    if (emit) begin
      px_r   <= px_calc;
      py_r   <= py_calc;
      pv_r   <= pv_calc;
      last_r <= last_calc;
      dres_r <= dres_calc;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_point_x     = px_r;
  assign out_point_y     = py_r;
  assign out_point_valid = pv_r;
  assign out_last_of_run = last_r;
  assign out_done_res    = dres_r;

endmodule

`default_nettype wire

// File: rtl/midpoint_circle_outline.sv
// Midpoint circle outline generator. A start item (func 0) loads a center
// and a radius and yields the eight symmetric outline points of (0, radius);
// each step item (func 1) runs one integer midpoint iteration and yields the
// next eight points, in the order (u,v), (v,u), (v,-u), (u,-v), (-u,-v),
// (-v,-u), (-v,u), (-u,v), each offset by the center and wrapped to
// COORD_WIDTH bits. Points on the axes and the diagonal are repeated, not
// filtered. A step once the outline is complete, or before any start, yields
// a single item with point_valid low and done_res high. The last item of
// each run carries last_of_run. A front end takes one item per cycle while
// the queue is not full and updates the circle state at once; a two-entry
// queue feeds a back end that sends one point per cycle through its output
// register while out_stall is low, so a start or step item yields eight
// output items and a done marker one. The front end can take new items while
// the back end still expands an earlier job; an item's first point passes
// through the queue and the output register. There are no configuration
// registers, and reset clears the circle state so that no circle is running.

`default_nettype none

module midpoint_circle_outline #(
  parameter int COORD_WIDTH  = mco_pkg::COORD_WIDTH_DEF,
  parameter int RADIUS_WIDTH = mco_pkg::RADIUS_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic signed [COORD_WIDTH-2:0]  in_center_x,
  input  wire logic signed [COORD_WIDTH-2:0]  in_center_y,
  input  wire logic        [RADIUS_WIDTH-1:0] in_radius,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [COORD_WIDTH-1:0]       out_point_x,
  output logic signed [COORD_WIDTH-1:0]       out_point_y,
  output logic                                out_point_valid,
  output logic                                out_last_of_run,
  output logic                                out_done_res
);

  import mco_pkg::*;

  // One queued job: control flags, center and the (u, v) pair to mirror.
  localparam int JOB_W = $bits(mco_ctl_t) + 2 * (COORD_WIDTH - 1) + 2 * RADIUS_WIDTH;

  logic                           q_push, q_pop, q_full, q_nempty;
  logic [JOB_W-1:0]               q_din, q_dout;

  mco_ctl_t                       job_ctl, head_ctl;
  logic signed [COORD_WIDTH-2:0]  job_cx, job_cy, head_cx, head_cy;
  logic        [RADIUS_WIDTH-1:0] job_u, job_v, head_u, head_v;

  // The front end classifies each item and advances the midpoint state.
  mco_front #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_func     (in_func),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_full      (q_full),
    .q_push      (q_push),
    .job_ctl     (job_ctl),
    .job_cx      (job_cx),
    .job_cy      (job_cy),
    .job_u       (job_u),
    .job_v       (job_v)
  );

  assign q_din = {job_ctl, job_cx, job_cy, job_u, job_v};

  mco_queue #(
    .W     (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .din    (q_din),
    .full   (q_full),
    .pop    (q_pop),
    .dout   (q_dout),
    .nempty (q_nempty)
  );

  assign {head_ctl, head_cx, head_cy, head_u, head_v} = q_dout;

  // The back end expands each job into its points, one per cycle unless out_stall holds it.
  mco_back #(
    .COORD_WIDTH  (COORD_WIDTH),
    .RADIUS_WIDTH (RADIUS_WIDTH)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_nempty        (q_nempty),
    .q_pop           (q_pop),
    .head_ctl        (head_ctl),
    .head_cx         (head_cx),
    .head_cy         (head_cy),
    .head_u          (head_u),
    .head_v          (head_v),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_point_x     (out_point_x),
    .out_point_y     (out_point_y),
    .out_point_valid (out_point_valid),
    .out_last_of_run (out_last_of_run),
    .out_done_res    (out_done_res)
  );

endmodule

`default_nettype wire
